// ----- design/mass_pkg.sv -----
// shared constants, codes and control types for the moving average spectral subtract unit
package mass_pkg;

   // storage limits
   localparam int MAX_COLS = 64;
   localparam int MAX_WIN  = 16;

   // field widths
   localparam int SAMPLE_W    = 32;
   localparam int COLUMN_W    = 6;
   localparam int WEIGHT_W    = 16;
   localparam int WINDOW_W    = 5;
   localparam int COLUMNS_W   = 7;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // derived widths
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int WIN_BITS   = $clog2(MAX_WIN);
   localparam int HIST_DEPTH = MAX_COLS * MAX_WIN;
   localparam int SUM_W      = 38;
   localparam int FRAC_W     = 12;
   localparam int PROD_W     = SUM_W + WEIGHT_W;
   localparam int DIFF_W     = PROD_W - FRAC_W + 2;
   localparam int STEP_W     = $clog2(SUM_W);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = CSR_INDEX_W'(2);

   // register reset values
   localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET  = WEIGHT_W'(4096);
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(MAX_WIN);
   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = COLUMNS_W'(MAX_COLS);

   // largest positive result
   localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   // controller to datapath
   typedef struct packed {
      logic load;
      logic read;
      logic update;
      logic div_step;
      logic mul;
      logic sub;
      logic out_load;
   } mass_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic active;
   } mass_status_type;

endpackage

// ----- design/mass_req_if.sv -----
// request and response channel interfaces
interface mass_req_if;
   import mass_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [COLUMN_W-1:0]        column;
   logic                       restart;

   modport source (output valid, output sample, output column, output restart, input ready);
   modport sink   (input valid, input sample, input column, input restart, output ready);
endinterface

interface mass_rsp_if;
   import mass_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] result;
   logic [COLUMN_W-1:0]        result_column;

   modport source (output valid, output result, output result_column, input ready);
   modport sink   (input valid, input result, input result_column, output ready);
endinterface

// ----- design/moving_average_spectral_subtract_unit.sv -----
// top level of the moving average spectral subtract unit
//
//   channel  direction  transfer when        carries
//   req      in         valid && ready       sample, column, restart
//   rsp      out        valid && ready       result, result_column
//   csr      in         csr_wr_en            weight, window_len, num_columns
//
// an averaged column is processed whole before the next transfer is accepted,
// with the 38-step bit-serial divide of the column sum by the fill count
// column 0 and columns beyond the row skip the divide and go straight to the output
// synchronous reset loads register defaults and marks every column sum empty
// the finished result waits in its own register, so a new item is taken
// while rsp is stalled; only loading the next result waits for rsp to drain
module moving_average_spectral_subtract_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   mass_req_if.sink                             req,
   mass_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [mass_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mass_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mass_pkg::*;

   mass_cmd_type    ctrl_cmd;
   mass_status_type dp_status;

   // sequencing: accept, ram read, sum update, divide, multiply, subtract, output
   mass_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // history ram, column sums with per column empty flags, arithmetic
   mass_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .status            (dp_status),
      .req_sample        (req.sample),
      .req_column        (req.column),
      .req_restart       (req.restart),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_result        (rsp.result),
      .rsp_result_column (rsp.result_column)
   );

   // one item in flight: busy straight after a transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request taken while an item is in flight");

   // controller issues at most one command per cycle
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl_cmd))
      else $error("more than one datapath command at once");

   // the divider starts right after the sum update
   a_divide_follows_update: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.update |=> ctrl_cmd.div_step)
      else $error("divide did not follow sum update");

   // a result appears only after it was loaded
   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(ctrl_cmd.out_load))
      else $error("response valid without output load");
endmodule

// ----- design/mass_ram.sv -----
// generic single write port ram with registered read
module mass_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/mass_ctrl.sv -----
// controller state machine sequencing one item through the datapath
module mass_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   input  mass_pkg::mass_status_type status,
   output mass_pkg::mass_cmd_type    cmd
);
   import mass_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_DIVIDE,
      S_MULTIPLY,
      S_SUBTRACT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.active ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            step_in    = '0;
            state_in   = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = S_MULTIPLY;
            end
         end
         S_MULTIPLY: begin
            cmd.mul  = 1'b1;
            state_in = S_SUBTRACT;
         end
         S_SUBTRACT: begin
            cmd.sub  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- design/mass_datapath.sv -----
// datapath: registers, history and sum rams, serial divider, weight multiply, output register
module mass_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mass_pkg::mass_cmd_type                cmd,
   output mass_pkg::mass_status_type             status,
   input  logic signed [mass_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [mass_pkg::COLUMN_W-1:0]         req_column,
   input  logic                                  req_restart,
   input  logic                                  csr_wr_en,
   input  logic [mass_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mass_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic signed [mass_pkg::SAMPLE_W-1:0]  rsp_result,
   output logic [mass_pkg::COLUMN_W-1:0]         rsp_result_column
);
   import mass_pkg::*;

   // configuration and running state
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic [COLUMNS_W-1:0] columns_ff, columns_in;
   logic [MAX_COLS-1:0]  valid_ff, valid_in;
   logic [WIN_BITS-1:0]  ring_ff, ring_in;
   logic [WINDOW_W-1:0]  rows_ff, rows_in;

   // item payload and arithmetic
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [COLUMN_W-1:0]  col_ff, col_in;
   logic                 active_ff, active_in;
   logic                 neg_ff, neg_in;
   logic [WINDOW_W-1:0]  divisor_ff, divisor_in;
   logic [WINDOW_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]     qr_ff, qr_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SAMPLE_W-1:0]  res_ff, res_in;
   logic [SAMPLE_W-1:0]  out_result_ff, out_result_in;
   logic [COLUMN_W-1:0]  out_column_ff, out_column_in;

   logic [WINDOW_W-1:0]             win_eff;
   logic [COLUMNS_W-1:0]            cols_eff;
   logic [COL_BITS-1:0]             col_idx;
   logic [COL_BITS+WIN_BITS-1:0]    hist_addr;
   logic [SUM_W-1:0]                sum_rd, sum_old, evict, sum_new, sum_mag;
   logic [SAMPLE_W-1:0]             hist_rd;
   logic [WINDOW_W-1:0]             rows_inc, count, ring_inc;
   logic                            row_end;
   logic [WINDOW_W:0]               trial, trial_diff;
   logic                            fits;
   logic [DIFF_W-1:0]               wm_ext, wm_signed, sample_ext, diff;

   // clamp configuration into the supported range
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WINDOW_W'(1);
      end else if (window_ff > WINDOW_W'(MAX_WIN)) begin
         win_eff = WINDOW_W'(MAX_WIN);
      end else begin
         win_eff = window_ff;
      end
      if (columns_ff < COLUMNS_W'(2)) begin
         cols_eff = COLUMNS_W'(2);
      end else if (columns_ff > COLUMNS_W'(MAX_COLS)) begin
         cols_eff = COLUMNS_W'(MAX_COLS);
      end else begin
         cols_eff = columns_ff;
      end
   end

   assign status.active = (req_column != '0) && (COLUMNS_W'(req_column) < cols_eff);

   assign col_idx   = col_ff[COL_BITS-1:0];
   assign hist_addr = {col_idx, ring_ff};

   mass_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (col_idx),
      .wr_data (sum_new),
      .rd_en   (cmd.read),
      .rd_addr (col_idx),
      .rd_data (sum_rd)
   );

   mass_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (hist_addr),
      .wr_data (sample_ff),
      .rd_en   (cmd.read),
      .rd_addr (hist_addr),
      .rd_data (hist_rd)
   );

   // running sum update, oldest row drops out once the window is full
   always_comb begin
      sum_old  = valid_ff[col_idx] ? sum_rd : '0;
      evict    = (rows_ff >= win_eff) ?
                 {{(SUM_W-SAMPLE_W){hist_rd[SAMPLE_W-1]}}, hist_rd} : '0;
      sum_new  = sum_old - evict + {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      sum_mag  = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
      rows_inc = rows_ff + WINDOW_W'(1);
      count    = (rows_inc > win_eff) ? win_eff : rows_inc;
      ring_inc = WINDOW_W'(ring_ff) + WINDOW_W'(1);
      row_end  = (COLUMNS_W'(col_ff) == cols_eff - COLUMNS_W'(1));
   end

   // one restoring divide step
   always_comb begin
      trial      = {rem_ff, qr_ff[SUM_W-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
   end

   // subtract weighted mean, floor at zero, saturate high
   always_comb begin
      wm_ext     = {2'b00, prod_ff[PROD_W-1:FRAC_W]};
      wm_signed  = neg_ff ? (~wm_ext + DIFF_W'(1)) : wm_ext;
      sample_ext = {{(DIFF_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      diff       = sample_ext - wm_signed;
   end

   always_comb begin
      weight_in     = weight_ff;
      window_in     = window_ff;
      columns_in    = columns_ff;
      valid_in      = valid_ff;
      ring_in       = ring_ff;
      rows_in       = rows_ff;
      sample_in     = sample_ff;
      col_in        = col_ff;
      active_in     = active_ff;
      neg_in        = neg_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      qr_in         = qr_ff;
      prod_in       = prod_ff;
      res_in        = res_ff;
      out_result_in = out_result_ff;
      out_column_in = out_column_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WEIGHT:  weight_in  = csr_wdata[WEIGHT_W-1:0];
            CSR_WINDOW:  window_in  = csr_wdata[WINDOW_W-1:0];
            CSR_COLUMNS: columns_in = csr_wdata[COLUMNS_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         sample_in = req_sample;
         col_in    = req_column;
         active_in = status.active;
         if (req_restart) begin
            valid_in = '0;
            ring_in  = '0;
            rows_in  = '0;
         end
      end

      if (cmd.update) begin
         valid_in[col_idx] = 1'b1;
         neg_in            = sum_new[SUM_W-1];
         qr_in             = sum_mag;
         rem_in            = '0;
         divisor_in        = count;
         if (row_end) begin
            ring_in = (ring_inc >= win_eff) ? '0 : ring_inc[WIN_BITS-1:0];
            if (rows_ff < win_eff) begin
               rows_in = rows_inc;
            end
         end
      end

      if (cmd.div_step) begin
         rem_in = fits ? trial_diff[WINDOW_W-1:0] : trial[WINDOW_W-1:0];
         qr_in  = {qr_ff[SUM_W-2:0], fits};
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(qr_ff) * PROD_W'(weight_ff);
      end

      if (cmd.sub) begin
         if (diff[DIFF_W-1]) begin
            res_in = '0;
         end else if (|diff[DIFF_W-2:SAMPLE_W-1]) begin
            res_in = SAT_MAX;
         end else begin
            res_in = diff[SAMPLE_W-1:0];
         end
      end

      if (cmd.out_load) begin
         out_result_in = active_ff ? res_ff : sample_ff;
         out_column_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= WEIGHT_RESET;
         window_ff  <= WINDOW_RESET;
         columns_ff <= COLUMNS_RESET;
         valid_ff   <= '0;
         ring_ff    <= '0;
         rows_ff    <= '0;
         active_ff  <= 1'b0;
      end else begin
         weight_ff  <= weight_in;
         window_ff  <= window_in;
         columns_ff <= columns_in;
         valid_ff   <= valid_in;
         ring_ff    <= ring_in;
         rows_ff    <= rows_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      col_ff        <= col_in;
      neg_ff        <= neg_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      qr_ff         <= qr_in;
      prod_ff       <= prod_in;
      res_ff        <= res_in;
      out_result_ff <= out_result_in;
      out_column_ff <= out_column_in;
   end

   assign rsp_result        = out_result_ff;
   assign rsp_result_column = out_column_ff;
endmodule

// ----- tb/sv/moving_average_spectral_subtract_unit_tb.sv -----
// self-checking testbench for the moving average spectral subtract unit
`timescale 1ns / 1ps

module moving_average_spectral_subtract_unit_tb;
   import mass_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 60;        // well past the processing of an averaged bin
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_PHASES  = 12;
   localparam int BINS_PER_PHASE = 142;
   localparam int DIRECTED_ROWS  = 28;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;

   // one denoised bin as it leaves the block
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result;
      logic [COLUMN_W-1:0]        column;
   } denoised_bin_type;

   // one row of the directed table: either a register write or a bin transfer
   typedef struct packed {
      logic                       reg_write;
      logic [CSR_INDEX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]      value;
      logic signed [SAMPLE_W-1:0] sample;
      logic [COLUMN_W-1:0]        column;
      logic                       restart;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] typed_result;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mass_req_if req_ch ();
   mass_rsp_if rsp_ch ();

   moving_average_spectral_subtract_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor copy of the registers
   logic [WEIGHT_W-1:0]  cfg_weight;
   logic [WINDOW_W-1:0]  cfg_window;
   logic [COLUMNS_W-1:0] cfg_columns;

   // predictor copy of the averaging state
   logic signed [SAMPLE_W-1:0] past_bins [HIST_DEPTH];
   bit [HIST_DEPTH-1:0]        past_written;   // slots stored since power-up
   logic [SUM_W-1:0]           run_sum [MAX_COLS];
   int                         ring_slot;
   int                         rows_filled;

   denoised_bin_type pending_bins [$];
   stim_row_type     directed_rows [DIRECTED_ROWS];

   int mismatch_count  = 0;
   int bins_sent;
   int results_checked = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count     = 0;

   // window and row length as the block applies them, out-of-range values clamped
   function automatic int active_window();
      if (cfg_window == '0) return 1;
      if (cfg_window > MAX_WIN) return MAX_WIN;
      return int'(cfg_window);
   endfunction

   function automatic int active_columns();
      if (cfg_columns < 2) return 2;
      if (cfg_columns > MAX_COLS) return MAX_COLS;
      return int'(cfg_columns);
   endfunction

   // true when this bin would take out of the sum a slot never stored
   function automatic bit would_read_blank(logic [COLUMN_W-1:0] col, logic restart);
      if (restart || col == '0 || col >= active_columns()) return 1'b0;
      if (rows_filled < active_window()) return 1'b0;
      return !past_written[int'(col) * MAX_WIN + ring_slot];
   endfunction

   // subtracts the weighted column mean from one bin and advances the averaging state
   function automatic denoised_bin_type denoise_bin(logic signed [SAMPLE_W-1:0] sample,
                                                    logic [COLUMN_W-1:0] col, logic restart);
      denoised_bin_type out_bin;
      int               win;
      int               ncols;
      int               count;
      int               slot;
      longint           total;
      longint           mean;
      longint           weighted;
      longint           diff;
      win   = active_window();
      ncols = active_columns();
      out_bin.result = sample;
      out_bin.column = col;
      if (restart) begin
         foreach (run_sum[c]) run_sum[c] = '0;
         ring_slot   = 0;
         rows_filled = 0;
      end
      // column 0 and bins beyond the row pass straight through
      if (col != '0 && col < ncols) begin
         slot  = int'(col) * MAX_WIN + ring_slot;
         count = (rows_filled + 1 > win) ? win : rows_filled + 1;
         total = $signed(run_sum[col]);
         // oldest row drops out once the window is full
         if (rows_filled >= win) total = total - past_bins[slot];
         past_bins[slot]    = sample;
         past_written[slot] = 1'b1;
         total = total + sample;
         run_sum[col] = total[SUM_W-1:0];       // sums wrap in 38 bits
         total    = $signed(run_sum[col]);
         mean     = total / count;
         weighted = (mean * longint'(cfg_weight)) / 4096;
         diff     = sample - weighted;
         if (diff > longint'(SAT_MAX)) diff = longint'(SAT_MAX);
         if (diff < 0) diff = 0;
         out_bin.result = diff[SAMPLE_W-1:0];
         // last column of the row steps the ring
         if (col == ncols - 1) begin
            ring_slot = (ring_slot + 1 >= win) ? 0 : ring_slot + 1;
            if (rows_filled < win) rows_filled++;
         end
      end
      return out_bin;
   endfunction

   function automatic stim_row_type bin_row(logic signed [SAMPLE_W-1:0] sample,
                                            logic [COLUMN_W-1:0] column, logic restart,
                                            logic typed,
                                            logic signed [SAMPLE_W-1:0] typed_result);
      stim_row_type row;
      row              = '0;
      row.sample       = sample;
      row.column       = column;
      row.restart      = restart;
      row.typed        = typed;
      row.typed_result = typed_result;
      return row;
   endfunction

   function automatic stim_row_type reg_row(logic [CSR_INDEX_W-1:0] index,
                                            logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row           = '0;
      row.reg_write = 1'b1;
      row.index     = index;
      row.value     = value;
      return row;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("[cycle %0d] mismatch: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // register write, only ever issued while the block is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_WEIGHT:  cfg_weight  = value[WEIGHT_W-1:0];
         CSR_WINDOW:  cfg_window  = value[WINDOW_W-1:0];
         CSR_COLUMNS: cfg_columns = value[COLUMNS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // one bin transfer on req; the prediction is queued at the accepting edge
   task automatic send_bin(input logic signed [SAMPLE_W-1:0] sample,
                           input logic [COLUMN_W-1:0] column, input logic restart,
                           input logic typed, input logic signed [SAMPLE_W-1:0] typed_result);
      denoised_bin_type predicted;
      // random gap before the transfer, valid low throughout
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.sample  <= sample;
      req_ch.column  <= column;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = denoise_bin(sample, column, restart);
      if (typed) predicted.result = typed_result;
      pending_bins.push_back(predicted);
      bins_sent++;
   endtask

   // stop sending, let every queued result come back, then let the block settle
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new register setting, then mostly well-formed rows with some noise and broken rows
   task automatic run_matrix_phase(input int phase);
      int                         ncols;
      int                         next_col;
      int                         pick;
      bit                         fresh;
      logic [COLUMN_W-1:0]        col;
      logic                       restart;
      logic signed [SAMPLE_W-1:0] value;
      // idling regime: sender-light, then receiver-light, then back to back
      case (phase * 3 / RANDOM_PHASES)
         0: begin
            send_idle_pct = 38;
            recv_idle_pct = 53;
         end
         1: begin
            send_idle_pct = 53;
            recv_idle_pct = 38;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      case ($urandom_range(0, 5))
         0: write_reg(CSR_WEIGHT, 16'd0);
         1: write_reg(CSR_WEIGHT, 16'hFFFF);
         2: write_reg(CSR_WEIGHT, 16'(WEIGHT_RESET));
         default: write_reg(CSR_WEIGHT, 16'($urandom_range(0, 65535)));
      endcase
      case ($urandom_range(0, 5))
         0: write_reg(CSR_WINDOW, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(17, 31)));
         1: write_reg(CSR_WINDOW, 16'(MAX_WIN));
         2: write_reg(CSR_WINDOW, 16'd1);
         default: write_reg(CSR_WINDOW, 16'($urandom_range(1, MAX_WIN)));
      endcase
      // short rows mostly, so windows fill and wrap within a phase
      case ($urandom_range(0, 7))
         0: write_reg(CSR_COLUMNS, 16'($urandom_range(0, 1)));
         1: write_reg(CSR_COLUMNS, 16'($urandom_range(MAX_COLS, 127)));
         2: write_reg(CSR_COLUMNS, 16'($urandom_range(9, MAX_COLS)));
         default: write_reg(CSR_COLUMNS, 16'($urandom_range(2, 8)));
      endcase
      ncols    = active_columns();
      next_col = 0;
      // sometimes carry on the previous matrix under the new setting
      fresh    = ($urandom_range(0, 99) < 85);
      for (int k = 0; k < BINS_PER_PHASE; k++) begin
         pick    = $urandom_range(0, 99);
         restart = 1'b0;
         if (pick < 85) begin
            col      = COLUMN_W'(next_col);
            restart  = fresh && k == 0;
            next_col = (next_col + 1 >= ncols) ? 0 : next_col + 1;
         end else if (pick < 93) begin
            // stray bin anywhere in the column range
            col     = COLUMN_W'($urandom_range(0, 63));
            restart = ($urandom_range(0, 7) == 0);
         end else if (pick < 99) begin
            // skipped bins: jump within the row
            next_col = $urandom_range(0, ncols - 1);
            col      = COLUMN_W'(next_col);
            next_col = (next_col + 1 >= ncols) ? 0 : next_col + 1;
         end else begin
            col      = '0;
            restart  = 1'b1;
            next_col = 1;
         end
         case ($urandom_range(0, 9))
            0, 1: value = $urandom;
            2: value = 0 - $urandom_range(0, 32'h0010_0000);
            default: value = $urandom_range(0, 32'h0040_0000);
         endcase
         // never make the block take out a slot that was never stored
         if (would_read_blank(col, restart)) col = '0;
         send_bin(value, col, restart, 1'b0, '0);
      end
   endtask

   // receiver: random stalls, every rsp transfer checked against the oldest prediction
   always @(posedge clock) begin : rsp_check
      denoised_bin_type oldest;
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bins.size() == 0) begin
            flag_mismatch($sformatf("result %h for column %0d with nothing outstanding",
                                    rsp_ch.result, rsp_ch.result_column));
         end else begin
            oldest = pending_bins.pop_front();
            if (rsp_ch.result !== oldest.result)
               flag_mismatch($sformatf("column %0d result %h, predicted %h",
                                       oldest.column, rsp_ch.result, oldest.result));
            if (rsp_ch.result_column !== oldest.column)
               flag_mismatch($sformatf("result_column %0d, predicted %0d",
                                       rsp_ch.result_column, oldest.column));
            results_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_bins.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.sample  <= '0;
      req_ch.column  <= '0;
      req_ch.restart <= 1'b0;
      bins_sent       = 0;
      send_idle_pct   = 38;
      recv_idle_pct   = 53;
      cfg_weight      = WEIGHT_RESET;
      cfg_window      = WINDOW_RESET;
      cfg_columns     = COLUMNS_RESET;
      foreach (run_sum[c]) run_sum[c] = '0;
      past_written    = '0;
      ring_slot       = 0;
      rows_filled     = 0;

      directed_rows = '{
         // register defaults: column 0 passes both extremes, restart on column 0
         bin_row(MOST_NEGATIVE, COLUMN_W'(0), 1'b1, 1'b1, MOST_NEGATIVE),
         bin_row(SAT_MAX, COLUMN_W'(0), 1'b0, 1'b1, SAT_MAX),
         // first row at unit weight: each bin is its own mean
         bin_row(SAT_MAX, COLUMN_W'(1), 1'b0, 1'b1, '0),
         bin_row(MOST_NEGATIVE, COLUMN_W'(2), 1'b0, 1'b1, '0),
         bin_row(32'sh0001_2345, COLUMN_W'(63), 1'b0, 1'b1, '0),
         bin_row(32'sh0002_0000, COLUMN_W'(1), 1'b0, 1'b0, '0),
         bin_row('0, COLUMN_W'(63), 1'b0, 1'b0, '0),
         // zero weight: plain floor at zero
         reg_row(CSR_WEIGHT, 16'd0),
         bin_row(SAT_MAX, COLUMN_W'(1), 1'b0, 1'b1, SAT_MAX),
         bin_row(32'shFFFF_0000, COLUMN_W'(2), 1'b0, 1'b1, '0),
         // top weight, window 0 acts as 1, row length 1 acts as 2, mid-matrix change
         reg_row(CSR_WEIGHT, 16'hFFFF),
         reg_row(CSR_WINDOW, 16'd0),
         reg_row(CSR_COLUMNS, 16'd1),
         bin_row(32'sh0001_0000, COLUMN_W'(1), 1'b0, 1'b0, '0),
         bin_row(32'sh0003_0000, COLUMN_W'(1), 1'b0, 1'b0, '0),
         // columns beyond the row pass through untouched
         bin_row(32'sh1234_5678, COLUMN_W'(5), 1'b0, 1'b1, 32'sh1234_5678),
         bin_row(MOST_NEGATIVE, COLUMN_W'(63), 1'b0, 1'b1, MOST_NEGATIVE),
         // negative mean under top weight saturates
         reg_row(CSR_WINDOW, 16'd2),
         reg_row(CSR_COLUMNS, 16'd2),
         bin_row(MOST_NEGATIVE, COLUMN_W'(1), 1'b1, 1'b1, SAT_MAX),
         bin_row('0, COLUMN_W'(1), 1'b0, 1'b1, SAT_MAX),
         bin_row(32'sh0001_0000, COLUMN_W'(1), 1'b0, 1'b0, '0),
         // oversized window and row length clamp to the maxima
         reg_row(CSR_WEIGHT, 16'd4096),
         reg_row(CSR_WINDOW, 16'd31),
         reg_row(CSR_COLUMNS, 16'd127),
         bin_row(32'sh4000_0000, COLUMN_W'(63), 1'b1, 1'b1, '0),
         bin_row('0, COLUMN_W'(0), 1'b0, 1'b1, '0),
         bin_row(32'sh0000_8000, COLUMN_W'(1), 1'b0, 1'b0, '0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reg_write) begin
            drain_block();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_bin(directed_rows[i].sample, directed_rows[i].column,
                     directed_rows[i].restart, directed_rows[i].typed,
                     directed_rows[i].typed_result);
         end
      end
      drain_block();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         run_matrix_phase(p);
         drain_block();
      end

      $display("%0d bin transfers: directed table, then %0d random register settings",
               bins_sent, RANDOM_PHASES);
      $display("%0d denoised bins compared, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
design/mass_pkg.sv
design/mass_req_if.sv
design/mass_ram.sv
design/mass_ctrl.sv
design/mass_datapath.sv
design/moving_average_spectral_subtract_unit.sv
tb/sv/moving_average_spectral_subtract_unit_tb.sv
